/* design/rlmv_pkg.sv */
// Shared types and constants of the region-of-interest luma statistics unit.
// Holds field widths, register indexes, multiplier selects and the command and
// status structs between controller and datapath. Depends on nothing.
package rlmv_pkg;

  localparam int LUMA_W     = 8;
  localparam int PITCH_W    = 14;
  localparam int DIM_W      = 13;
  localparam int ROI_W      = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam int MEAN_W = 16;
  localparam int VAR_W  = 22;
  localparam int CNT_W  = 25;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 64;

  // Signed width for region bounds and pixel positions.
  localparam int XW      = 17;
  localparam int N_W     = 2 * DIM_W;
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 40;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int HALF_SQ = SQ_W / 2;
  localparam int ALO_W   = N_W + HALF_SQ;
  localparam int A_W     = N_W + SQ_W;
  localparam int DEN_W   = 2 * N_W;
  localparam int FRAC_W  = 8;
  localparam int QB      = VAR_W;
  localparam int STEP_W  = 5;

  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(MEAN_W);
  localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(VAR_W);
  localparam logic [MEAN_W-1:0] MEAN_MAX   = '1;
  localparam logic [VAR_W-1:0]  VAR_MAX    = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_PITCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT   = 3'd6;

  typedef enum logic [1:0] {
    MUL_SS,
    MUL_NN,
    MUL_LO,
    MUL_HI
  } mul_sel_e;

  typedef struct packed {
    logic     pix_en;
    logic     capture;
    logic     snap;
    mul_sel_e mul_sel;
    logic     store_b;
    logic     store_d;
    logic     store_alo;
    logic     sum_a;
    logic     diff;
    logic     div_start;
    logic     div_var;
    logic     mean_store;
    logic     mean_sat;
    logic     var_store;
    logic     var_sat;
    logic     out_load;
  } rlmv_cmd_t;

  typedef struct packed {
    logic nonempty;
    logic num_pos;
    logic mean_ovf;
    logic var_ovf;
    logic div_busy;
    logic div_done;
  } rlmv_status_t;

endpackage

/* design/rlmv_div.sv */
// Restoring divider, one quotient bit per cycle, for the mean and variance.
// The caller supplies a partial remainder below the divisor and the dividend
// bits still to shift in. Depends on rlmv_pkg.
module rlmv_div import rlmv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DEN_W-1:0]  rem_i,
  input  logic [QB-1:0]     bits_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [STEP_W-1:0] steps_i,
  output logic [QB-1:0]     quot_o,
  output logic              busy_o,
  output logic              done_o
);

  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [QB-1:0]     bits_q;
  logic [DEN_W-1:0]  den_q;
  logic [QB-1:0]     quot_q;
  logic [STEP_W-1:0] cnt_q;
  logic              done_q;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    trial_sub;
  logic              fits;

  assign trial     = {rem_q, bits_q[QB-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign fits      = trial >= {1'b0, den_q};
  assign rem_d     = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= steps_i;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      bits_q <= bits_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      bits_q <= {bits_q[QB-2:0], 1'b0};
      quot_q <= {quot_q[QB-2:0], fits};
    end
  end

  assign quot_o = quot_q;
  assign busy_o = cnt_q != '0;
  assign done_o = done_q;

endmodule

/* design/rlmv_dp.sv */
// Datapath: configuration registers, pixel position counters, region test,
// running sums, shared multiplier, divider operands and result registers.
// Depends on rlmv_pkg and rlmv_div.
module rlmv_dp import rlmv_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [LUMA_W-1:0]      luma_i,
  input  logic                   frame_end_i,
  input  rlmv_cmd_t              cmd_i,
  output rlmv_status_t           status_o,
  output logic [TDATA_OUT_W-1:0] m_data_o
);

  localparam int CW = $clog2(2 * MAX_DIM);
  localparam logic [CW-1:0] ROW_MAX   = CW'(2 * MAX_DIM - 1);
  localparam logic [31:0]   DIM_MAX   = 32'(MAX_DIM);
  localparam logic [31:0]   PITCH_MAX = 32'(2 * MAX_DIM);

  logic [PITCH_W-1:0] pitch_q;
  logic [DIM_W-1:0]   pw_q, ph_q;
  logic [ROI_W-1:0]   left_q, top_q, rw_q, rh_q;

  logic [CW-1:0]      col_q, row_q;
  logic [CW:0]        col_p1;
  logic               wrap;
  logic               cfg_ok;

  logic signed [XW-1:0] l_s, t_s, e_s, b_s, pw_s, ph_s;
  logic signed [XW-1:0] x0, x1, y0, y1, wd_s, ht_s, col_s, row_s;
  logic                 nonempty_c, hit;

  logic              acc_en_q;
  logic [LUMA_W-1:0] pix_q;
  logic [SUM_W-1:0]  sum_q, s_q;
  logic [SQ_W-1:0]   sqsum_q, sq_q;

  logic [DIM_W-1:0]  wd_q, ht_q;
  logic              nonempty_q;
  logic [N_W-1:0]    n_q;

  logic [MUL_W-1:0]  op_a, op_b;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] b_q;
  logic [DEN_W-1:0]  d_q;
  logic [ALO_W-1:0]  alo_q;
  logic [A_W-1:0]    a_q, num_q;
  logic              num_pos_q;

  logic [DEN_W-1:0]  div_rem, div_den;
  logic [QB-1:0]     div_bits, quot;
  logic [STEP_W-1:0] div_steps;
  logic              div_busy, div_done;

  logic [MEAN_W-1:0] res_mean_q, out_mean_q;
  logic [VAR_W-1:0]  res_var_q, out_var_q;
  logic [CNT_W-1:0]  out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q <= '0;
      pw_q    <= '0;
      ph_q    <= '0;
      left_q  <= '0;
      top_q   <= '0;
      rw_q    <= '0;
      rh_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LINE_PITCH:   pitch_q <= cfg_data_i;
        CFG_PLANE_WIDTH:  pw_q    <= cfg_data_i[DIM_W-1:0];
        CFG_PLANE_HEIGHT: ph_q    <= cfg_data_i[DIM_W-1:0];
        CFG_ROI_LEFT:     left_q  <= cfg_data_i;
        CFG_ROI_TOP:      top_q   <= cfg_data_i;
        CFG_ROI_WIDTH:    rw_q    <= cfg_data_i;
        CFG_ROI_HEIGHT:   rh_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ok = (pitch_q != '0) && (pw_q != '0) && (ph_q != '0) &&
                  (32'(pw_q) <= DIM_MAX) && (32'(ph_q) <= DIM_MAX) &&
                  (pitch_q >= PITCH_W'(pw_q)) && (32'(pitch_q) <= PITCH_MAX);

  assign l_s  = XW'(signed'(left_q));
  assign t_s  = XW'(signed'(top_q));
  assign e_s  = l_s + XW'(signed'(rw_q));
  assign b_s  = t_s + XW'(signed'(rh_q));
  assign pw_s = signed'(XW'(pw_q));
  assign ph_s = signed'(XW'(ph_q));
  assign x0   = (l_s > 0) ? l_s : '0;
  assign y0   = (t_s > 0) ? t_s : '0;
  assign x1   = (e_s < pw_s) ? e_s : pw_s;
  assign y1   = (b_s < ph_s) ? b_s : ph_s;
  assign wd_s = x1 - x0;
  assign ht_s = y1 - y0;
  assign nonempty_c = cfg_ok && (x1 > x0) && (y1 > y0);

  assign col_s = signed'(XW'(col_q));
  assign row_s = signed'(XW'(row_q));
  assign hit   = nonempty_c && (col_s >= x0) && (col_s < x1) &&
                 (row_s >= y0) && (row_s < y1);

  assign col_p1 = {1'b0, col_q} + (CW+1)'(1);
  assign wrap   = (32'(col_p1) >= 32'(pitch_q)) || (col_q >= ROW_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      acc_en_q <= 1'b0;
      sum_q    <= '0;
      sqsum_q  <= '0;
    end else begin
      acc_en_q <= cmd_i.pix_en && hit;
      if (cmd_i.pix_en) begin
        if (frame_end_i) begin
          col_q <= '0;
          row_q <= '0;
        end else if (wrap) begin
          col_q <= '0;
          if (row_q < ROW_MAX) begin
            row_q <= row_q + CW'(1);
          end
        end else begin
          col_q <= col_p1[CW-1:0];
        end
      end
      if (cmd_i.snap) begin
        sum_q   <= '0;
        sqsum_q <= '0;
      end else if (acc_en_q) begin
        sum_q   <= sum_q + SUM_W'(pix_q);
        sqsum_q <= sqsum_q + SQ_W'((2*LUMA_W)'(pix_q) * (2*LUMA_W)'(pix_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_en) begin
      pix_q <= luma_i;
    end
    if (cmd_i.capture) begin
      wd_q       <= wd_s[DIM_W-1:0];
      ht_q       <= ht_s[DIM_W-1:0];
      nonempty_q <= nonempty_c;
    end
    if (cmd_i.snap) begin
      s_q        <= sum_q;
      sq_q       <= sqsum_q;
      n_q        <= nonempty_q ? N_W'(wd_q) * N_W'(ht_q) : '0;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_SS: begin
        op_a = s_q;
        op_b = s_q;
      end
      MUL_NN: begin
        op_a = MUL_W'(n_q);
        op_b = MUL_W'(n_q);
      end
      MUL_LO: begin
        op_a = MUL_W'(n_q);
        op_b = MUL_W'(sq_q[HALF_SQ-1:0]);
      end
      MUL_HI: begin
        op_a = MUL_W'(n_q);
        op_b = MUL_W'(sq_q[SQ_W-1:HALF_SQ]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
    if (cmd_i.store_b) begin
      b_q <= prod_q;
    end
    if (cmd_i.store_d) begin
      d_q <= prod_q[DEN_W-1:0];
    end
    if (cmd_i.store_alo) begin
      alo_q <= prod_q[ALO_W-1:0];
    end
    if (cmd_i.sum_a) begin
      a_q <= A_W'(alo_q) + {prod_q[ALO_W-1:0], {HALF_SQ{1'b0}}};
    end
    if (cmd_i.diff) begin
      num_q     <= a_q - A_W'(b_q);
      num_pos_q <= a_q > A_W'(b_q);
    end
    if (cmd_i.snap) begin
      res_mean_q <= '0;
    end else if (cmd_i.mean_store) begin
      res_mean_q <= quot[MEAN_W-1:0];
    end else if (cmd_i.mean_sat) begin
      res_mean_q <= MEAN_MAX;
    end
    if (cmd_i.snap) begin
      res_var_q <= '0;
    end else if (cmd_i.var_store) begin
      res_var_q <= quot;
    end else if (cmd_i.var_sat) begin
      res_var_q <= VAR_MAX;
    end
    if (cmd_i.out_load) begin
      out_mean_q <= res_mean_q;
      out_var_q  <= res_var_q;
      out_cnt_q  <= n_q[CNT_W-1:0];
    end
  end

  always_comb begin
    if (cmd_i.div_var) begin
      div_rem   = num_q[A_W-1:QB-FRAC_W];
      div_bits  = {num_q[QB-FRAC_W-1:0], {FRAC_W{1'b0}}};
      div_den   = d_q;
      div_steps = VAR_STEPS;
    end else begin
      div_rem   = DEN_W'(s_q[SUM_W-1:FRAC_W]);
      div_bits  = {s_q[FRAC_W-1:0], {(QB-FRAC_W){1'b0}}};
      div_den   = DEN_W'(n_q);
      div_steps = MEAN_STEPS;
    end
  end

  rlmv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .rem_i   (div_rem),
    .bits_i  (div_bits),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quot_o  (quot),
    .busy_o  (div_busy),
    .done_o  (div_done)
  );

  assign status_o.nonempty = nonempty_q;
  assign status_o.num_pos  = num_pos_q;
  assign status_o.mean_ovf = DEN_W'(s_q[SUM_W-1:FRAC_W]) >= DEN_W'(n_q);
  assign status_o.var_ovf  = num_q[A_W-1:QB-FRAC_W] >= d_q;
  assign status_o.div_busy = div_busy;
  assign status_o.div_done = div_done;

  assign m_data_o = {1'b0, out_cnt_q, out_var_q, out_mean_q};

endmodule

/* design/rlmv_ctrl.sv */
// Controller: sequences pixel intake, the end-of-frame multiplications and
// divisions, and the output handshake. Depends on rlmv_pkg.
module rlmv_ctrl import rlmv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_last_i,
  output logic         s_ready_o,
  input  logic         m_ready_i,
  output logic         m_valid_o,
  input  rlmv_status_t status_i,
  output rlmv_cmd_t    cmd_o
);

  localparam logic [3:0] S_ACC   = 4'd0;
  localparam logic [3:0] S_FLUSH = 4'd1;
  localparam logic [3:0] S_SNAP  = 4'd2;
  localparam logic [3:0] S_MSS   = 4'd3;
  localparam logic [3:0] S_MNN   = 4'd4;
  localparam logic [3:0] S_MLO   = 4'd5;
  localparam logic [3:0] S_MHI   = 4'd6;
  localparam logic [3:0] S_MSUM  = 4'd7;
  localparam logic [3:0] S_MNUM  = 4'd8;
  localparam logic [3:0] S_DMEAN = 4'd9;
  localparam logic [3:0] S_DMW   = 4'd10;
  localparam logic [3:0] S_DVAR  = 4'd11;
  localparam logic [3:0] S_DVW   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mul_sel = MUL_SS;
    unique case (state_q)
      S_ACC: begin
        cmd_o.pix_en = s_valid_i;
        if (s_valid_i && s_last_i) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        cmd_o.capture = 1'b1;
        state_d = S_SNAP;
      end
      S_SNAP: begin
        cmd_o.snap = 1'b1;
        state_d = status_i.nonempty ? S_MSS : S_OUT;
      end
      S_MSS: begin
        state_d = S_MNN;
      end
      S_MNN: begin
        cmd_o.mul_sel = MUL_NN;
        cmd_o.store_b = 1'b1;
        state_d = S_MLO;
      end
      S_MLO: begin
        cmd_o.mul_sel = MUL_LO;
        cmd_o.store_d = 1'b1;
        state_d = S_MHI;
      end
      S_MHI: begin
        cmd_o.mul_sel   = MUL_HI;
        cmd_o.store_alo = 1'b1;
        state_d = S_MSUM;
      end
      S_MSUM: begin
        cmd_o.sum_a = 1'b1;
        state_d = S_MNUM;
      end
      S_MNUM: begin
        cmd_o.diff = 1'b1;
        state_d = S_DMEAN;
      end
      S_DMEAN: begin
        if (status_i.mean_ovf) begin
          cmd_o.mean_sat = 1'b1;
          state_d = S_DVAR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DMW;
        end
      end
      S_DMW: begin
        if (status_i.div_done) begin
          cmd_o.mean_store = 1'b1;
          state_d = S_DVAR;
        end
      end
      S_DVAR: begin
        cmd_o.div_var = 1'b1;
        priority if (!status_i.num_pos) begin
          state_d = S_OUT;
        end else if (status_i.var_ovf) begin
          cmd_o.var_sat = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_DVW;
        end
      end
      S_DVW: begin
        cmd_o.div_var = 1'b1;
        if (status_i.div_done) begin
          cmd_o.var_store = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign s_ready_o = state_q == S_ACC;
  assign m_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i))
    else $error("pending result overwritten");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy)
    else $error("divider started while busy");

  a_intake_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_ready_o |-> !status_i.div_busy)
    else $error("pixel intake while divider runs");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_o) |-> ($past(state_q) == S_OUT))
    else $error("result raised outside output state");

endmodule

/* design/roi_luma_mean_variance_unit.sv */
// Region-of-interest luma mean and variance unit, top level.
// Streaming input of luma samples, streaming output of per-frame statistics,
// and a register write channel. Depends on rlmv_pkg, rlmv_ctrl and rlmv_dp.
//
// Usage: write the seven registers (index 0 line pitch, 1 plane width,
// 2 plane height, 3 to 6 region left, top, width, height) on the cfg channel,
// which is always ready. Then stream one frame of 8-bit luma samples in raster
// order on the s_axis channel with tlast on the last sample of the frame.
// Samples are taken at one per clock outside end-of-frame processing. After
// the frame-end request the input stays stalled while one shared 32x32
// multiplier runs four products and a radix-2 divider produces the mean
// (16 steps) and the variance (22 steps); the result then enters the output
// register.
// The output channel carries one request per frame: mean (8.8), variance
// (14.8) and pixel count. A stalled receiver does not block the next frame;
// intake stops only if a second result is ready while the first still waits.
// Reset clears the configuration registers, the position counters and the
// sums; no clearing pass is needed.
module roi_luma_mean_variance_unit import rlmv_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // Bits 7:0 luma.
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // Bits 15:0 mean_q8, 37:16 variance_q8, 62:38 pixel_count, 63 zero.
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o
);

  rlmv_cmd_t    cmd;
  rlmv_status_t status;

  assign cfg_ready_o = 1'b1;

  rlmv_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rlmv_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .luma_i      (s_axis_tdata_i[LUMA_W-1:0]),
    .frame_end_i (s_axis_tlast_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_data_o    (m_axis_tdata_o)
  );

endmodule

/* dv/tb_roi_luma_mean_variance_unit.sv */
// Self-checking testbench for roi_luma_mean_variance_unit: streams luma frames,
// predicts the per-frame mean, variance and pixel count and checks every result.
// Depends on rlmv_pkg and the RTL of the unit.
module tb_roi_luma_mean_variance_unit import rlmv_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 4096;
  localparam int ROW_LAST = 2 * MAX_DIM - 1;
  localparam int RANDOM_ITEMS = 1520;
  localparam int MIN_FRAMES = 48;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic [CNT_W-1:0]  count;
  } frame_stats_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [TDATA_IN_W-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tlast_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata_o;

  logic [PITCH_W-1:0]      line_pitch_q = '0;
  logic [DIM_W-1:0]        plane_width_q = '0;
  logic [DIM_W-1:0]        plane_height_q = '0;
  logic signed [ROI_W-1:0] roi_left_q = '0;
  logic signed [ROI_W-1:0] roi_top_q = '0;
  logic signed [ROI_W-1:0] roi_width_q = '0;
  logic signed [ROI_W-1:0] roi_height_q = '0;

  int               pos_col = 0;
  int               pos_row = 0;
  bit [SUM_W-1:0]   luma_sum = '0;
  bit [SQ_W-1:0]    luma_square_sum = '0;
  frame_stats_t     expected_stats[$];

  int  gap_pct = 0;
  int  stall_pct = 0;
  int  errors = 0;
  int  samples_sent = 0;
  int  cycle_count = 0;

  roi_luma_mean_variance_unit #(
    .MAX_DIM(MAX_DIM)
  ) uut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tlast_i,
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_LINE_PITCH:   line_pitch_q = data;
      CFG_PLANE_WIDTH:  plane_width_q = data[DIM_W-1:0];
      CFG_PLANE_HEIGHT: plane_height_q = data[DIM_W-1:0];
      CFG_ROI_LEFT:     roi_left_q = data;
      CFG_ROI_TOP:      roi_top_q = data;
      CFG_ROI_WIDTH:    roi_width_q = data;
      CFG_ROI_HEIGHT:   roi_height_q = data;
      default: ;
    endcase
  endfunction

  function automatic void accumulate_sample(logic [LUMA_W-1:0] luma, logic last);
    bit           setup_ok;
    bit           nonempty;
    int           x0, x1, y0, y1, right, bottom;
    bit [63:0]    n, s, a, b, num, d, q, r, mean, variance;
    frame_stats_t stats;
    setup_ok = line_pitch_q != 0 && plane_width_q != 0 && plane_height_q != 0 &&
               int'(plane_width_q) <= MAX_DIM && int'(plane_height_q) <= MAX_DIM &&
               line_pitch_q >= plane_width_q && int'(line_pitch_q) <= 2 * MAX_DIM;
    right = int'(roi_left_q) + int'(roi_width_q);
    bottom = int'(roi_top_q) + int'(roi_height_q);
    x0 = roi_left_q > 0 ? int'(roi_left_q) : 0;
    y0 = roi_top_q > 0 ? int'(roi_top_q) : 0;
    x1 = right < int'(plane_width_q) ? right : int'(plane_width_q);
    y1 = bottom < int'(plane_height_q) ? bottom : int'(plane_height_q);
    nonempty = setup_ok && x1 > x0 && y1 > y0;
    if (nonempty && pos_col >= x0 && pos_col < x1 && pos_row >= y0 && pos_row < y1) begin
      luma_sum = luma_sum + luma;
      luma_square_sum = luma_square_sum + luma * luma;
    end
    if (pos_col + 1 >= int'(line_pitch_q) || pos_col >= ROW_LAST) begin
      pos_col = 0;
      if (pos_row < ROW_LAST) pos_row++;
    end else begin
      pos_col++;
    end
    if (!last) return;
    mean = '0;
    variance = '0;
    n = '0;
    if (nonempty) begin
      n = 64'(x1 - x0) * 64'(y1 - y0);
      s = 64'(luma_sum);
      mean = (s << 8) / n;
      if (mean > 64'(MEAN_MAX)) mean = 64'(MEAN_MAX);
      a = n * 64'(luma_square_sum);
      b = s * s;
      if (a > b) begin
        num = a - b;
        d = n * n;
        q = num / d;
        r = num % d;
        if (q > 64'(VAR_MAX >> FRAC_W)) begin
          variance = 64'(VAR_MAX);
        end else begin
          variance = (q << FRAC_W) + (r << FRAC_W) / d;
          if (variance > 64'(VAR_MAX)) variance = 64'(VAR_MAX);
        end
      end
    end
    stats.mean = mean[MEAN_W-1:0];
    stats.variance = variance[VAR_W-1:0];
    stats.count = n[CNT_W-1:0];
    expected_stats.push_back(stats);
    pos_col = 0;
    pos_row = 0;
    luma_sum = '0;
    luma_square_sum = '0;
  endfunction

  always @(posedge clk_i) begin
    frame_stats_t want;
    logic [MEAN_W-1:0] got_mean;
    logic [VAR_W-1:0]  got_variance;
    logic [CNT_W-1:0]  got_count;
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_mean = m_axis_tdata_o[MEAN_W-1:0];
      got_variance = m_axis_tdata_o[MEAN_W +: VAR_W];
      got_count = m_axis_tdata_o[MEAN_W+VAR_W +: CNT_W];
      if (expected_stats.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (got_mean !== want.mean) begin
          $display("%0t: mean_q8 expected %0d, got %0d", $time, want.mean, got_mean);
          errors++;
        end
        if (got_variance !== want.variance) begin
          $display("%0t: variance_q8 expected %0d, got %0d", $time, want.variance,
                   got_variance);
          errors++;
        end
        if (got_count !== want.count) begin
          $display("%0t: pixel_count expected %0d, got %0d", $time, want.count, got_count);
          errors++;
        end
        if (m_axis_tdata_o[TDATA_OUT_W-1] !== 1'b0) begin
          $display("%0t: tdata bit 63 expected 0, got %b", $time,
                   m_axis_tdata_o[TDATA_OUT_W-1]);
          errors++;
        end
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin gap_pct = 83; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 83; end
      default:       begin gap_pct = 7;  stall_pct = 7;  end
    endcase
  endtask

  task automatic send_sample(input logic [LUMA_W-1:0] luma, input logic last);
    if ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < gap_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= luma;
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    accumulate_sample(luma, last);
    samples_sent++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write channel valid; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, data);
  endtask

  task automatic program_setup(input int pitch, input int width, input int height,
                               input int left, input int top, input int roi_w,
                               input int roi_h);
    write_reg(CFG_LINE_PITCH, CFG_DATA_W'(pitch));
    write_reg(CFG_PLANE_WIDTH, CFG_DATA_W'(width));
    write_reg(CFG_PLANE_HEIGHT, CFG_DATA_W'(height));
    write_reg(CFG_ROI_LEFT, CFG_DATA_W'(left));
    write_reg(CFG_ROI_TOP, CFG_DATA_W'(top));
    write_reg(CFG_ROI_WIDTH, CFG_DATA_W'(roi_w));
    write_reg(CFG_ROI_HEIGHT, CFG_DATA_W'(roi_h));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    set_idling(IDLE_NONE);
    send_sample(8'hA5, 1'b1);
  endtask

  task automatic test_field_extremes();
    logic [LUMA_W-1:0] pattern [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80};
    set_idling(IDLE_NONE);
    wait_idle();
    program_setup(4, 4, 2, 0, 0, 4, 2);
    foreach (pattern[i]) send_sample(pattern[i], i == 7);
    wait_idle();
    // A negative origin trims the region instead of moving it.
    program_setup(4, 4, 2, -2, -1, 4, 3);
    foreach (pattern[i]) send_sample(~pattern[i], i == 7);
    wait_idle();
    program_setup(4, 4, 2, 8191, 0, -8192, 0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h00, 1'b1);
    wait_idle();
    program_setup(8192, 4096, 4096, 0, 0, 8191, 8191);
    send_sample(8'hFF, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h00, 1'b1);
    wait_idle();
    write_reg(CFG_UNUSED, '1);
    program_setup(16383, 8191, 8191, -8192, -8192, 8191, 8191);
    send_sample(8'h7F, 1'b0);
    send_sample(8'h80, 1'b1);
    wait_idle();
    program_setup(3, 4, 2, 0, 0, 4, 2);
    send_sample(8'hFF, 1'b1);
  endtask

  // The region shrinks while the frame is open, so the mean saturates and the
  // variance numerator goes negative; the lowered pitch also ends the line early.
  task automatic test_midframe_change();
    set_idling(IDLE_NONE);
    wait_idle();
    program_setup(4, 4, 4, 0, 0, 4, 4);
    repeat (5) send_sample(8'hFF, 1'b0);
    wait_idle();
    write_reg(CFG_LINE_PITCH, CFG_DATA_W'(2));
    write_reg(CFG_ROI_WIDTH, CFG_DATA_W'(1));
    write_reg(CFG_ROI_HEIGHT, CFG_DATA_W'(1));
    cfg_valid_i <= 1'b0;
    send_sample(8'hFF, 1'b0);
    send_sample(8'h10, 1'b1);
  endtask

  task automatic random_setup();
    int pitch, width, height;
    if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    case ($urandom_range(0, 9))
      0: program_setup($urandom_range(0, 16383), $urandom_range(0, 16383),
                       $urandom_range(0, 16383), $urandom_range(0, 16383),
                       $urandom_range(0, 16383), $urandom_range(0, 16383),
                       $urandom_range(0, 16383));
      1: program_setup($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 3),
                       int'($urandom_range(0, 6)) - 2, int'($urandom_range(0, 4)) - 2,
                       int'($urandom_range(0, 8)) - 2, int'($urandom_range(0, 5)) - 2);
      default: begin
        pitch = $urandom_range(1, 12);
        width = $urandom_range(1, pitch);
        height = $urandom_range(1, 5);
        program_setup(pitch, width, height,
                      int'($urandom_range(0, width + 3)) - 3,
                      int'($urandom_range(0, height + 2)) - 2,
                      int'($urandom_range(0, width + 4)) - 2,
                      int'($urandom_range(0, height + 3)) - 2);
      end
    endcase
  endtask

  task automatic random_register_change();
    case ($urandom_range(0, 6))
      0: write_reg(CFG_LINE_PITCH, CFG_DATA_W'($urandom_range(1, 12)));
      1: write_reg(CFG_PLANE_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
      2: write_reg(CFG_PLANE_HEIGHT, CFG_DATA_W'($urandom_range(1, 6)));
      3: write_reg(CFG_ROI_LEFT, CFG_DATA_W'(int'($urandom_range(0, 8)) - 3));
      4: write_reg(CFG_ROI_TOP, CFG_DATA_W'(int'($urandom_range(0, 6)) - 2));
      5: write_reg(CFG_ROI_WIDTH, CFG_DATA_W'(int'($urandom_range(0, 10)) - 2));
      default: write_reg(CFG_ROI_HEIGHT, CFG_DATA_W'(int'($urandom_range(0, 7)) - 2));
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [LUMA_W-1:0] pick_luma(int kind);
    case (kind)
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'hFF;
      default: return LUMA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_random_frames();
    int start, frames, len, split, kind, phase;
    start = samples_sent;
    frames = 0;
    while (samples_sent - start < RANDOM_ITEMS || frames < MIN_FRAMES) begin
      phase = (samples_sent - start) * 4 / RANDOM_ITEMS;
      set_idling(idle_mode_e'(phase > 3 ? 3 : phase));
      if (frames == 0 || $urandom_range(0, 2) != 0) begin
        wait_idle();
        random_setup();
      end
      len = int'(line_pitch_q) * int'(plane_height_q);
      if (len == 0 || len > 48) len = $urandom_range(1, 40);
      if ($urandom_range(0, 3) == 0) len = len + int'($urandom_range(0, 6)) - 3;
      if (len < 1) len = 1;
      split = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
      kind = $urandom_range(0, 3);
      for (int k = 0; k < len; k++) begin
        if (split != 0 && k == split) begin
          wait_idle();
          random_register_change();
        end
        send_sample(pick_luma(kind), k == len - 1);
      end
      frames++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_field_extremes();
    test_midframe_change();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
